// ===== hw/rtl/gscc_pkg.sv =====
`timescale 1ns / 1ps
package gscc_pkg;

  localparam int GRID_COLS_DEF = 256;
  localparam int GRID_ROWS_DEF = 256;

  // Shared divider: quotient and numerator width, divisor and remainder width.
  localparam int DIV_NUM_W = 54;
  localparam int DIV_DEN_W = 33;

  // Square root of a sum of two 64-bit squares.
  localparam int SQ_IN_W   = 66;
  localparam int SQ_ROOT_W = 33;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_POINT   = 2'd1;
  localparam logic [1:0] CMD_SEGMENT = 2'd2;
  localparam logic [1:0] CMD_ENDS    = 2'd3;

  localparam logic [2:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] CFG_CELL_SIZE = 3'd2;
  localparam logic [2:0] CFG_WIDTH     = 3'd3;
  localparam logic [2:0] CFG_HEIGHT    = 3'd4;
  localparam logic [2:0] CFG_THRESHOLD = 3'd5;

  localparam logic [20:0] CELL_SIZE_RST = 21'd3277;
  localparam logic [8:0]  WIDTH_RST     = 9'd256;
  localparam logic [8:0]  HEIGHT_RST    = 9'd256;
  localparam logic [7:0]  THRESHOLD_RST = 8'd253;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_SEG_ABS,
    S_SEG_SQX,
    S_SEG_SQY,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_STEPS_GO,
    S_STEPS_WAIT,
    S_STX_MUL,
    S_STX_GO,
    S_STX_WAIT,
    S_STY_MUL,
    S_STY_GO,
    S_STY_WAIT,
    S_PX_GO,
    S_PX_WAIT,
    S_PY_GO,
    S_PY_WAIT,
    S_LOOK,
    S_CMP,
    S_ADV
  } state_t;

endpackage

// ===== hw/rtl/gscc_div.sv =====
`timescale 1ns / 1ps
module gscc_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gscc_pkg::DIV_NUM_W-1:0] num,
  input  logic [gscc_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [gscc_pkg::DIV_NUM_W-1:0] quot,
  output logic [gscc_pkg::DIV_DEN_W-1:0] rem
);

  localparam int NW = gscc_pkg::DIV_NUM_W;
  localparam int DW = gscc_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] num_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          ge;

  // One quotient bit per cycle; the quotient shifts in behind the numerator.
  assign trial = {rem_r, num_r[NW-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
        num_r <= {num_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

// ===== hw/rtl/gscc_sqrt.sv =====
`timescale 1ns / 1ps
module gscc_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [gscc_pkg::SQ_IN_W-1:0]   radicand,
  output logic                           done,
  output logic [gscc_pkg::SQ_ROOT_W-1:0] root
);

  localparam int IW = gscc_pkg::SQ_IN_W;
  localparam int RW = gscc_pkg::SQ_ROOT_W;
  localparam int MW = RW + 2;
  localparam int CW = $clog2(RW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] val_r;
  logic [RW-1:0] root_r;
  logic [MW-1:0] rem_r;
  logic [MW+1:0] acc;
  logic [MW+1:0] trial;
  logic          ge;

  // Two radicand bits per cycle, one root bit.
  assign acc   = {rem_r, val_r[IW-1:IW-2]};
  assign trial = (MW + 2)'({root_r, 2'b01});
  assign ge    = acc >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(RW);
        val_r  <= radicand;
        root_r <= '0;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? MW'(acc - trial) : acc[MW-1:0];
        root_r <= {root_r[RW-2:0], ge};
        val_r  <= {val_r[IW-3:0], 2'b00};
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== hw/rtl/grid_segment_collision_check.sv =====
`timescale 1ns / 1ps
// Cost-grid collision checker. After reset the grid is cleared one cell per
// cycle with busy high; configuration writes are taken at any time. A cell
// write is done in the idle state as the command is taken. A point check makes
// two passes through the shared radix-2 divider that maps x and y to a cell;
// an endpoint check maps each endpoint in turn. A segment check runs a 33-bit
// square root, three divider passes and one point mapping, then reads the grid
// memory for each sample, up to GRID_COLS+GRID_ROWS samples. Each transaction
// yields one result, shown for exactly one cycle on out_valid; the receiver
// cannot stall it, so it must take every result when it appears.
module grid_segment_collision_check #(
  parameter int GRID_COLS = gscc_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gscc_pkg::GRID_ROWS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic [7:0]         in_cell_col,
  input  logic [7:0]         in_cell_row,
  input  logic [7:0]         in_cell_cost,
  output logic               out_valid,
  output logic               out_blocked,
  output logic               out_left_map,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int DEPTH  = GRID_COLS * GRID_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COLS_W = $clog2(GRID_COLS + 1);
  localparam int ROWS_W = $clog2(GRID_ROWS + 1);
  localparam int CAP    = GRID_COLS + GRID_ROWS;
  localparam int STEP_W = $clog2(CAP + 1);
  localparam int NW     = gscc_pkg::DIV_NUM_W;
  localparam int DW     = gscc_pkg::DIV_DEN_W;
  localparam int QW     = 35;
  localparam int RW     = 24;

  gscc_pkg::state_t state_r, state_nxt;

  logic signed [31:0] origin_x_r, origin_y_r;
  logic [20:0]        cell_size_r;
  logic [8:0]         width_r, height_r;
  logic [7:0]         thr_r;

  logic [1:0]         cmd_r;
  logic signed [31:0] fx_r, fy_r, tx_r, ty_r;
  logic signed [31:0] px_r, py_r;
  logic               second_r;
  logic               dxneg_r, dyneg_r;
  logic [31:0]        ax_r, ay_r;
  logic [63:0]        sqx_r, sqy_r;
  logic [32:0]        d_r;
  logic [NW-1:0]      prod_r;
  logic [STEP_W-1:0]  steps_r, i_r;
  logic signed [22:0] stx_r, sty_r;
  logic signed [QW-1:0] qx_r, qy_r;
  logic signed [RW-1:0] rx_r, ry_r;
  logic [ADDR_W-1:0]  clear_addr_r;

  logic               out_valid_r, out_blocked_r, out_left_r;

  logic [7:0]         mem [DEPTH];
  logic [7:0]         rdata_r;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [7:0]         mem_wdata;

  logic               fin, fin_blk, fin_left;
  logic               accept;

  logic               div_start, div_done;
  logic [NW-1:0]      div_num, div_quot;
  logic [DW-1:0]      div_den, div_rem;
  logic               sq_start, sq_done;
  logic [32:0]        sq_root;

  logic [20:0]        cs_eff;
  logic [COLS_W-1:0]  cols_eff;
  logic [ROWS_W-1:0]  rows_eff;
  logic signed [32:0] dx, dy, ox, oy;
  logic               outside;
  logic [ADDR_W-1:0]  look_addr, write_addr;
  logic               write_ok;
  logic signed [RW-1:0] rxs, rys, cs_s;
  logic signed [QW-1:0] q_pos, q_sel;
  logic [RW-1:0]      r_sel;
  logic               neg_sel;

  assign accept    = start && !busy;
  assign busy      = (state_r != gscc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  assign cs_eff   = (cell_size_r == '0) ? 21'd1 : cell_size_r;
  assign cols_eff = (int'(width_r) < GRID_COLS) ? COLS_W'(width_r) : COLS_W'(GRID_COLS);
  assign rows_eff = (int'(height_r) < GRID_ROWS) ? ROWS_W'(height_r) : ROWS_W'(GRID_ROWS);
  assign cs_s     = $signed(RW'(cs_eff));

  assign dx = 33'(tx_r) - 33'(fx_r);
  assign dy = 33'(ty_r) - 33'(fy_r);
  assign ox = 33'(px_r) - 33'(origin_x_r);
  assign oy = 33'(py_r) - 33'(origin_y_r);

  assign outside = (qx_r < 0) || (qy_r < 0) ||
                   (qx_r >= $signed(QW'(cols_eff))) || (qy_r >= $signed(QW'(rows_eff)));
  assign look_addr  = ADDR_W'(qy_r[ROW_W-1:0]) * ADDR_W'(GRID_COLS)
                    + ADDR_W'(qx_r[COL_W-1:0]);
  assign write_addr = ADDR_W'(in_cell_row) * ADDR_W'(GRID_COLS) + ADDR_W'(in_cell_col);
  assign write_ok   = (int'(in_cell_col) < GRID_COLS) && (int'(in_cell_row) < GRID_ROWS);

  assign rxs = rx_r + RW'(stx_r);
  assign rys = ry_r + RW'(sty_r);

  // Floor division of a negative offset: divide -o-1, then quotient -q-1 and
  // remainder cs-1-r.
  assign neg_sel = (state_r == gscc_pkg::S_PX_WAIT) ? ox[32] : oy[32];
  assign q_pos   = $signed(QW'(div_quot[32:0]));
  assign q_sel   = neg_sel ? ~q_pos : q_pos;
  assign r_sel   = neg_sel ? RW'(cs_eff - 21'd1 - div_rem[20:0]) : RW'(div_rem[20:0]);

  gscc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot),
    .rem   (div_rem)
  );

  gscc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (66'(sqx_r) + 66'(sqy_r)),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gscc_pkg::S_CLEAR: begin
        if (clear_addr_r == ADDR_W'(DEPTH - 1)) state_nxt = gscc_pkg::S_IDLE;
      end
      gscc_pkg::S_IDLE: begin
        if (start) begin
          if (in_cmd == gscc_pkg::CMD_SEGMENT) state_nxt = gscc_pkg::S_SEG_ABS;
          else if (in_cmd != gscc_pkg::CMD_WRITE) state_nxt = gscc_pkg::S_PX_GO;
        end
      end
      gscc_pkg::S_SEG_ABS:   state_nxt = gscc_pkg::S_SEG_SQX;
      gscc_pkg::S_SEG_SQX:   state_nxt = gscc_pkg::S_SEG_SQY;
      gscc_pkg::S_SEG_SQY:   state_nxt = gscc_pkg::S_ROOT_GO;
      gscc_pkg::S_ROOT_GO:   state_nxt = gscc_pkg::S_ROOT_WAIT;
      gscc_pkg::S_ROOT_WAIT: if (sq_done) state_nxt = gscc_pkg::S_STEPS_GO;
      gscc_pkg::S_STEPS_GO:  state_nxt = gscc_pkg::S_STEPS_WAIT;
      gscc_pkg::S_STEPS_WAIT: begin
        if (div_done) state_nxt = (div_quot == '0) ? gscc_pkg::S_IDLE : gscc_pkg::S_STX_MUL;
      end
      gscc_pkg::S_STX_MUL:   state_nxt = gscc_pkg::S_STX_GO;
      gscc_pkg::S_STX_GO:    state_nxt = gscc_pkg::S_STX_WAIT;
      gscc_pkg::S_STX_WAIT:  if (div_done) state_nxt = gscc_pkg::S_STY_MUL;
      gscc_pkg::S_STY_MUL:   state_nxt = gscc_pkg::S_STY_GO;
      gscc_pkg::S_STY_GO:    state_nxt = gscc_pkg::S_STY_WAIT;
      gscc_pkg::S_STY_WAIT:  if (div_done) state_nxt = gscc_pkg::S_PX_GO;
      gscc_pkg::S_PX_GO:     state_nxt = gscc_pkg::S_PX_WAIT;
      gscc_pkg::S_PX_WAIT:   if (div_done) state_nxt = gscc_pkg::S_PY_GO;
      gscc_pkg::S_PY_GO:     state_nxt = gscc_pkg::S_PY_WAIT;
      gscc_pkg::S_PY_WAIT:   if (div_done) state_nxt = gscc_pkg::S_LOOK;
      gscc_pkg::S_LOOK:      state_nxt = outside ? gscc_pkg::S_IDLE : gscc_pkg::S_CMP;
      gscc_pkg::S_CMP: begin
        if (rdata_r >= thr_r) state_nxt = gscc_pkg::S_IDLE;
        else if (cmd_r == gscc_pkg::CMD_SEGMENT) begin
          state_nxt = ((i_r + 1'b1) == steps_r) ? gscc_pkg::S_IDLE : gscc_pkg::S_ADV;
        end else if (second_r) state_nxt = gscc_pkg::S_PX_GO;
        else state_nxt = gscc_pkg::S_IDLE;
      end
      gscc_pkg::S_ADV:       state_nxt = gscc_pkg::S_LOOK;
      default:               state_nxt = gscc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = DW'(cs_eff);
    sq_start  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = look_addr;
    mem_wdata = in_cell_cost;
    fin       = 1'b0;
    fin_blk   = 1'b0;
    fin_left  = 1'b0;
    unique case (state_r)
      gscc_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clear_addr_r;
        mem_wdata = '0;
      end
      gscc_pkg::S_IDLE: begin
        if (start && in_cmd == gscc_pkg::CMD_WRITE) begin
          mem_we   = write_ok;
          mem_addr = write_addr;
          fin      = 1'b1;
        end
      end
      gscc_pkg::S_ROOT_GO: sq_start = 1'b1;
      gscc_pkg::S_STEPS_GO: begin
        div_start = 1'b1;
        div_num   = NW'(d_r);
      end
      gscc_pkg::S_STEPS_WAIT: fin = div_done && (div_quot == '0);
      gscc_pkg::S_STX_GO, gscc_pkg::S_STY_GO: begin
        div_start = 1'b1;
        div_num   = prod_r;
        div_den   = d_r;
      end
      gscc_pkg::S_PX_GO: begin
        div_start = 1'b1;
        div_num   = NW'(ox[32] ? ~ox : ox);
      end
      gscc_pkg::S_PY_GO: begin
        div_start = 1'b1;
        div_num   = NW'(oy[32] ? ~oy : oy);
      end
      gscc_pkg::S_LOOK: begin
        fin      = outside;
        fin_blk  = 1'b1;
        fin_left = 1'b1;
      end
      gscc_pkg::S_CMP: begin
        if (rdata_r >= thr_r) begin
          fin     = 1'b1;
          fin_blk = 1'b1;
        end else if (cmd_r == gscc_pkg::CMD_SEGMENT) fin = ((i_r + 1'b1) == steps_r);
        else fin = !second_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= gscc_pkg::S_CLEAR;
      clear_addr_r <= '0;
      out_valid_r  <= 1'b0;
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      cell_size_r  <= gscc_pkg::CELL_SIZE_RST;
      width_r      <= gscc_pkg::WIDTH_RST;
      height_r     <= gscc_pkg::HEIGHT_RST;
      thr_r        <= gscc_pkg::THRESHOLD_RST;
      second_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
      if (state_r == gscc_pkg::S_CLEAR) clear_addr_r <= clear_addr_r + 1'b1;
      if (cfg_valid) begin
        unique case (cfg_index)
          gscc_pkg::CFG_ORIGIN_X:  origin_x_r  <= cfg_data;
          gscc_pkg::CFG_ORIGIN_Y:  origin_y_r  <= cfg_data;
          gscc_pkg::CFG_CELL_SIZE: cell_size_r <= cfg_data[20:0];
          gscc_pkg::CFG_WIDTH:     width_r     <= cfg_data[8:0];
          gscc_pkg::CFG_HEIGHT:    height_r    <= cfg_data[8:0];
          gscc_pkg::CFG_THRESHOLD: thr_r       <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) second_r <= (in_cmd == gscc_pkg::CMD_ENDS);
      else if (state_r == gscc_pkg::S_CMP && second_r) second_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_blocked_r <= fin_blk;
      out_left_r    <= fin_left;
    end
    if (accept) begin
      cmd_r <= in_cmd;
      fx_r  <= in_first_x;
      fy_r  <= in_first_y;
      tx_r  <= in_second_x;
      ty_r  <= in_second_y;
      px_r  <= in_first_x;
      py_r  <= in_first_y;
    end
    case (state_r)
      gscc_pkg::S_SEG_ABS: begin
        dxneg_r <= dx[32];
        dyneg_r <= dy[32];
        ax_r    <= 32'(dx[32] ? -dx : dx);
        ay_r    <= 32'(dy[32] ? -dy : dy);
      end
      gscc_pkg::S_SEG_SQX: sqx_r <= ax_r * ax_r;
      gscc_pkg::S_SEG_SQY: sqy_r <= ay_r * ay_r;
      gscc_pkg::S_ROOT_WAIT: if (sq_done) d_r <= sq_root;
      gscc_pkg::S_STEPS_WAIT: begin
        if (div_done) begin
          steps_r <= (div_quot > NW'(CAP)) ? STEP_W'(CAP) : div_quot[STEP_W-1:0];
        end
      end
      gscc_pkg::S_STX_MUL: prod_r <= NW'(ax_r * cs_eff) + NW'(d_r[32:1]);
      gscc_pkg::S_STY_MUL: prod_r <= NW'(ay_r * cs_eff) + NW'(d_r[32:1]);
      gscc_pkg::S_STX_WAIT: begin
        if (div_done) stx_r <= dxneg_r ? -$signed(23'(div_quot[21:0]))
                                      : $signed(23'(div_quot[21:0]));
      end
      gscc_pkg::S_STY_WAIT: begin
        if (div_done) begin
          sty_r <= dyneg_r ? -$signed(23'(div_quot[21:0])) : $signed(23'(div_quot[21:0]));
          i_r   <= '0;
        end
      end
      gscc_pkg::S_PX_WAIT: begin
        if (div_done) begin
          qx_r <= q_sel;
          rx_r <= r_sel;
        end
      end
      gscc_pkg::S_PY_WAIT: begin
        if (div_done) begin
          qy_r <= q_sel;
          ry_r <= r_sel;
        end
      end
      gscc_pkg::S_CMP: begin
        i_r <= i_r + 1'b1;
        if (second_r) begin
          px_r <= tx_r;
          py_r <= ty_r;
        end
      end
      gscc_pkg::S_ADV: begin
        // A step is at most one cell, so one correction keeps the remainder in range.
        if (rxs >= cs_s) begin
          rx_r <= rxs - cs_s;
          qx_r <= qx_r + QW'(1);
        end else if (rxs < 0) begin
          rx_r <= rxs + cs_s;
          qx_r <= qx_r - QW'(1);
        end else rx_r <= rxs;
        if (rys >= cs_s) begin
          ry_r <= rys - cs_s;
          qy_r <= qy_r + QW'(1);
        end else if (rys < 0) begin
          ry_r <= rys + cs_s;
          qy_r <= qy_r - QW'(1);
        end else ry_r <= rys;
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_blocked  = out_blocked_r;
  assign out_left_map = out_left_r;

endmodule

// ===== sim/tb_grid_segment_collision_check.sv =====
`timescale 1ns / 1ps
module tb_grid_segment_collision_check;

  localparam int COLS = 256;
  localparam int ROWS = 256;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [7:0]         col;
    logic [7:0]         row;
    logic [7:0]         cost;
    bit                 typed;
    logic               exp_blocked;
    logic               exp_left;
  } query_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_cmd = gscc_pkg::CMD_WRITE;
  logic signed [31:0] in_first_x = '0;
  logic signed [31:0] in_first_y = '0;
  logic signed [31:0] in_second_x = '0;
  logic signed [31:0] in_second_y = '0;
  logic [7:0]         in_cell_col = '0;
  logic [7:0]         in_cell_row = '0;
  logic [7:0]         in_cell_cost = '0;
  logic               out_valid;
  logic               out_blocked;
  logic               out_left_map;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = gscc_pkg::CFG_ORIGIN_X;
  logic [31:0]        cfg_data = '0;

  // Predictor state: grid copy and register copies.
  logic [7:0]  grid_copy [0:COLS*ROWS-1];
  logic [31:0] org_x, org_y;
  logic [20:0] cell_len;
  logic [8:0]  cols_used, rows_used;
  logic [7:0]  threshold;

  logic [1:0] pending_results [$];
  int errors = 0;

  grid_segment_collision_check dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .in_cell_col(in_cell_col), .in_cell_row(in_cell_row), .in_cell_cost(in_cell_cost),
    .out_valid(out_valid), .out_blocked(out_blocked), .out_left_map(out_left_map),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned eff_cell();
    return (cell_len == 0) ? 64'd1 : 64'(cell_len);
  endfunction

  function automatic bit probe_cell(input longint px, input longint py, output bit outside);
    longint unsigned cs, ncols, nrows, col, row;
    longint ox, oy;
    cs = eff_cell();
    ncols = (cols_used < COLS) ? 64'(cols_used) : COLS;
    nrows = (rows_used < ROWS) ? 64'(rows_used) : ROWS;
    ox = px - longint'(signed'(org_x));
    oy = py - longint'(signed'(org_y));
    outside = 1'b1;
    if (ox < 0 || oy < 0) return 1'b1;
    col = longint'(ox) / cs;
    row = longint'(oy) / cs;
    if (col >= ncols || row >= nrows) return 1'b1;
    outside = 1'b0;
    return grid_copy[row*COLS + col] >= threshold;
  endfunction

  function automatic longint unsigned root66(input logic [65:0] v);
    logic [69:0] rem;
    logic [69:0] trial;
    logic [69:0] root;
    rem = '0;
    root = '0;
    for (int p = 32; p >= 0; p--) begin
      rem = (rem << 2) | 70'((v >> (2*p)) & 66'd3);
      trial = (root << 2) | 70'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 70'd1;
      end else begin
        root = root << 1;
      end
    end
    return 64'(root);
  endfunction

  function automatic bit walk_segment(input longint fx, input longint fy, input longint tx,
                                      input longint ty, output bit outside);
    longint dx, dy, stx, sty;
    longint unsigned ax, ay, d, cs, steps;
    logic [65:0] sq;
    dx = tx - fx;
    dy = ty - fy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sq = 66'(ax) * 66'(ax) + 66'(ay) * 66'(ay);
    d = root66(sq);
    cs = eff_cell();
    steps = d / cs;
    outside = 1'b0;
    if (steps == 0) return 1'b0;
    if (steps > COLS + ROWS) steps = COLS + ROWS;
    stx = (ax * cs + d / 2) / d;
    sty = (ay * cs + d / 2) / d;
    if (dx < 0) stx = -stx;
    if (dy < 0) sty = -sty;
    for (longint i = 0; i < steps; i++) begin
      if (probe_cell(fx + i*stx, fy + i*sty, outside)) return 1'b1;
    end
    outside = 1'b0;
    return 1'b0;
  endfunction

  function automatic logic [1:0] predict_check(input query_t q);
    bit blk, outside;
    blk = 1'b0;
    outside = 1'b0;
    case (q.cmd)
      gscc_pkg::CMD_WRITE: grid_copy[{q.row, q.col}] = q.cost;
      gscc_pkg::CMD_POINT: blk = probe_cell(q.fx, q.fy, outside);
      gscc_pkg::CMD_SEGMENT: blk = walk_segment(q.fx, q.fy, q.sx, q.sy, outside);
      default: begin
        blk = probe_cell(q.fx, q.fy, outside);
        if (!blk) blk = probe_cell(q.sx, q.sy, outside);
      end
    endcase
    if (!blk) outside = 1'b0;
    return {blk, outside};
  endfunction

  task automatic send_query(input query_t q);
    logic [1:0] exp_res;
    in_cmd <= q.cmd;
    in_first_x <= q.fx;
    in_first_y <= q.fy;
    in_second_x <= q.sx;
    in_second_y <= q.sy;
    in_cell_col <= q.col;
    in_cell_row <= q.row;
    in_cell_cost <= q.cost;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    exp_res = predict_check(q);
    if (q.typed) exp_res = {q.exp_blocked, q.exp_left};
    pending_results.push_back(exp_res);
  endtask

  task automatic pause_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
  endtask

  // Leaves cfg_valid high so that writes can follow back to back.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      gscc_pkg::CFG_ORIGIN_X:  org_x = val;
      gscc_pkg::CFG_ORIGIN_Y:  org_y = val;
      gscc_pkg::CFG_CELL_SIZE: cell_len = val[20:0];
      gscc_pkg::CFG_WIDTH:     cols_used = val[8:0];
      gscc_pkg::CFG_HEIGHT:    rows_used = val[8:0];
      gscc_pkg::CFG_THRESHOLD: threshold = val[7:0];
      default: ;
    endcase
  endtask

  function automatic query_t make_query(input logic [1:0] cmd, input longint fx,
                                        input longint fy, input longint sx, input longint sy,
                                        input int col, input int row, input int cost,
                                        input bit typed, input bit eb, input bit el);
    query_t q;
    q.cmd = cmd;
    q.fx = 32'(fx);
    q.fy = 32'(fy);
    q.sx = 32'(sx);
    q.sy = 32'(sy);
    q.col = 8'(col);
    q.row = 8'(row);
    q.cost = 8'(cost);
    q.typed = typed;
    q.exp_blocked = eb;
    q.exp_left = el;
    return q;
  endfunction

  // A coordinate near the used part of the map, a few cells past each edge.
  function automatic longint near_map(input logic [31:0] org, input logic [8:0] used);
    longint unsigned cs, span;
    cs = eff_cell();
    span = cs * ((used > COLS) ? COLS : used);
    if (span > 64'd1 << 30) span = 64'd1 << 30;
    return longint'(signed'(org)) + longint'($urandom_range(0, 32'(span + 8*cs))) -
           longint'(4*cs);
  endfunction

  function automatic logic [31:0] pick_reg_value(input logic [2:0] idx);
    int r;
    r = $urandom_range(0, 9);
    case (idx)
      gscc_pkg::CFG_ORIGIN_X, gscc_pkg::CFG_ORIGIN_Y:
        if (r == 0) return 32'h8000_0000;
        else if (r == 1) return 32'h7FFF_FFFF;
        else if (r == 2) return $urandom;
        else return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      gscc_pkg::CFG_CELL_SIZE:
        if (r == 0) return 32'd1;
        else if (r == 1) return 32'd1048576;
        else if (r == 2) return (r == 2 && $urandom_range(0, 1)) ? 32'd0 : 32'h1F_FFFF;
        else return $urandom_range(500, 80000);
      gscc_pkg::CFG_WIDTH, gscc_pkg::CFG_HEIGHT:
        if (r == 0) return 32'd1;
        else if (r == 1) return 32'd256;
        else if (r == 2) return $urandom_range(0, 511);
        else return $urandom_range(2, 256);
      default:
        if (r == 0) return 32'd0;
        else if (r == 1) return 32'd255;
        else return $urandom_range(1, 255);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    int r;
    r = $urandom_range(0, 99);
    q = make_query(gscc_pkg::CMD_WRITE, longint'(signed'($urandom)),
                   longint'(signed'($urandom)),
                   longint'(signed'($urandom)), longint'(signed'($urandom)),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                   1'b0, 1'b0, 1'b0);
    if (r < 30) begin
      // Most writes land in the used region so that checks see obstacles.
      if (r < 24) begin
        q.col = 8'($urandom_range(0, (cols_used == 0 || cols_used > COLS) ? 255 : cols_used-1));
        q.row = 8'($urandom_range(0, (rows_used == 0 || rows_used > ROWS) ? 255 : rows_used-1));
        q.cost = $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(200, 255));
      end
    end else begin
      q.cmd = (r < 55) ? gscc_pkg::CMD_POINT :
              (r < 88) ? gscc_pkg::CMD_SEGMENT : gscc_pkg::CMD_ENDS;
      if (r % 10 != 0) begin
        q.fx = 32'(near_map(org_x, cols_used));
        q.fy = 32'(near_map(org_y, rows_used));
        q.sx = 32'(near_map(org_x, cols_used));
        q.sy = 32'(near_map(org_y, rows_used));
        if (q.cmd == gscc_pkg::CMD_SEGMENT && $urandom_range(0, 2) == 0) begin
          // Short segments of a few cells.
          q.sx = q.fx + 32'($signed($urandom_range(0, 8*eff_cell())) - 4*eff_cell());
          q.sy = q.fy + 32'($signed($urandom_range(0, 8*eff_cell())) - 4*eff_cell());
        end
      end
    end
    return q;
  endfunction

  always @(posedge clk) begin
    logic [1:0] exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result blocked=%0b left_map=%0b", $time, out_blocked,
                 out_left_map);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_blocked !== exp_res[1]) begin
          errors++;
          $display("%0t: blocked expected %0b actual %0b", $time, exp_res[1], out_blocked);
        end
        if (out_left_map !== exp_res[0]) begin
          errors++;
          $display("%0t: left_map expected %0b actual %0b", $time, exp_res[0], out_left_map);
        end
      end
    end
  end

  initial begin
    query_t directed [$];
    int total;
    int gap_left;
    org_x = '0;
    org_y = '0;
    cell_len = gscc_pkg::CELL_SIZE_RST;
    cols_used = gscc_pkg::WIDTH_RST;
    rows_used = gscc_pkg::HEIGHT_RST;
    threshold = gscc_pkg::THRESHOLD_RST;
    for (int i = 0; i < COLS*ROWS; i++) grid_copy[i] = '0;

    // Default map: 256 x 256 cells of 3277, so it spans 0 .. 838911 on each axis.
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, -1, 0, 0, 0, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 0, -1, 0, 0, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 838911, 838911, 0, 0,
                                  0, 0, 0, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 838912, 0, 0, 0, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                                  0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, -2147483648, -2147483648, 0, 0,
                                  0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_SEGMENT, 5000, 5000, 5000, 5000,
                                  0, 0, 0, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_SEGMENT, 5000, 5000, 6000, 5000,
                                  0, 0, 0, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_SEGMENT, -2147483648, -2147483648,
                                  2147483647, 2147483647, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_SEGMENT, 2147483647, -2147483648,
                                  -2147483648, 2147483647, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_ENDS, 100, 100, -5, 100, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_ENDS, -5, 100, 100, 100, 0, 0, 0, 1, 1, 1));
    directed.push_back(make_query(gscc_pkg::CMD_ENDS, 100, 100, 200000, 700000,
                                  0, 0, 0, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0, 255, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_WRITE, -1, -1, -1, -1, 255, 255, 253,
                                  1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_WRITE, 0, 0, 0, 0, 10, 0, 252, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 838911, 838911, 0, 0,
                                  0, 0, 0, 1, 1, 0));
    directed.push_back(make_query(gscc_pkg::CMD_POINT, 10*3277, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_ENDS, 100000, 100000, 0, 0,
                                  0, 0, 0, 1, 1, 0));
    directed.push_back(make_query(gscc_pkg::CMD_SEGMENT, 838000, 838000, 0, 0,
                                  0, 0, 0, 0, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_SEGMENT, 100000, 1638, 0, 1638,
                                  0, 0, 0, 0, 0, 0));
    directed.push_back(make_query(gscc_pkg::CMD_SEGMENT, 800000, 1000, 900000, 1000, 0, 0, 0,
                                  0, 0, 0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_query(directed[i]);

    total = directed.size();
    gap_left = 0;
    for (int phase = 0; phase < 9; phase++) begin
      // Each phase starts from an idle block with a fresh register setting.
      drain_results();
      for (int idx = gscc_pkg::CFG_ORIGIN_X; idx <= gscc_pkg::CFG_THRESHOLD; idx++) begin
        if (phase == 0 || $urandom_range(0, 2) != 0)
          write_reg(3'(idx), pick_reg_value(3'(idx)));
      end
      if (phase == 8) begin
        write_reg(gscc_pkg::CFG_ORIGIN_X, 32'd0);
        write_reg(gscc_pkg::CFG_ORIGIN_Y, 32'd0);
        write_reg(gscc_pkg::CFG_CELL_SIZE, 32'(gscc_pkg::CELL_SIZE_RST));
        write_reg(gscc_pkg::CFG_WIDTH, 32'(gscc_pkg::WIDTH_RST));
        write_reg(gscc_pkg::CFG_HEIGHT, 32'(gscc_pkg::HEIGHT_RST));
      end
      cfg_valid <= 1'b0;
      for (int n = 0; n < 115; n++) begin
        send_query(random_query());
        total++;
        if (phase < 8) begin
          if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 10);
          if (gap_left > 0) begin
            pause_cycles(gap_left);
            gap_left = 0;
          end
        end
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/gscc_pkg.sv
hw/rtl/gscc_div.sv
hw/rtl/gscc_sqrt.sv
hw/rtl/grid_segment_collision_check.sv
sim/tb_grid_segment_collision_check.sv
